/* design/arm32_multiply_unit_defines.svh */
// assertion macros shared by the multiply unit
`ifndef ARM32_MULTIPLY_UNIT_DEFINES_SVH
`define ARM32_MULTIPLY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define AMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AMU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/amu_pkg.sv */
`default_nettype none
package amu_pkg;
	localparam logic [3:0] PC_INDEX   = 4'd15;
	localparam logic [3:0] MODE_MUL   = 4'd0;
	localparam logic [3:0] MODE_MLA   = 4'd1;
	localparam logic [3:0] MODE_UMULL = 4'd2;
	localparam logic [3:0] MODE_UMLAL = 4'd3;
	localparam logic [3:0] MODE_SMULL = 4'd4;
	localparam logic [3:0] MODE_SMLAL = 4'd5;
	localparam logic [3:0] MODE_UMAAL = 4'd6;
	localparam logic [3:0] MODE_SMMUL = 4'd7;
	localparam logic [3:0] MODE_SMMLA = 4'd8;
	localparam logic [3:0] MODE_SMMLS = 4'd9;

	localparam int DIGIT_W   = 8;
	localparam int NUM_CELLS = 32 / DIGIT_W;

	typedef enum logic [1:0] {
		FORM_WORD = 2'b01,
		FORM_LONG = 2'b10
	} form_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic        cond_passed;
		logic        set_flags;
		logic        round_enable;
		logic [31:0] value_n;
		logic [31:0] value_m;
		logic [31:0] value_acc;
		logic [31:0] value_hi;
		logic [3:0]  index_dest;
		logic [3:0]  index_aux;
		logic [3:0]  index_n;
		logic [3:0]  index_m;
	} in_item_t;

	typedef struct packed {
		logic        unpredictable;
		logic        write_low;
		logic        write_high;
		logic [31:0] result_low;
		logic [31:0] result_high;
		logic        flags_write;
		logic        flag_negative;
		logic        flag_zero;
	} out_item_t;

	// control that rides along with the arithmetic
	typedef struct packed {
		logic  unp;
		logic  wlo;
		logic  whi;
		logic  fw;
		logic  msw;   // most-significant-word form
		form_t form;
	} ctl_t;

	typedef struct packed {
		logic        valid;
		ctl_t        ctl;
		logic        sub;
		logic [63:0] n;
		logic [31:0] m;
		logic [63:0] acc;
	} stage_t;
endpackage
`default_nettype wire

/* design/amu_stream_if.sv */
`default_nettype none
interface amu_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/amu_decode.sv */
`default_nettype none
module amu_decode (
	input  wire amu_pkg::in_item_t item,
	output amu_pkg::stage_t        stage
);
	logic        core_pc, is_long, is_smm, unp, go, signed_op, m_neg;
	logic [63:0] base, corr, rnd_add;
	logic [3:0]  op;

	always_comb begin
		op        = item.mode;
		core_pc   = (item.index_dest == amu_pkg::PC_INDEX) || (item.index_n == amu_pkg::PC_INDEX)
			|| (item.index_m == amu_pkg::PC_INDEX);
		is_long   = (op >= amu_pkg::MODE_UMULL) && (op <= amu_pkg::MODE_UMAAL);
		is_smm    = (op >= amu_pkg::MODE_SMMUL) && (op <= amu_pkg::MODE_SMMLS);
		unp       = (op > amu_pkg::MODE_SMMLS) || core_pc
			|| (((op == amu_pkg::MODE_MLA) || (op == amu_pkg::MODE_SMMLS))
				&& (item.index_aux == amu_pkg::PC_INDEX))
			|| (is_long && ((item.index_aux == amu_pkg::PC_INDEX)
				|| (item.index_aux == item.index_dest)));
		go        = !unp && item.cond_passed;
		signed_op = (op == amu_pkg::MODE_SMULL) || (op == amu_pkg::MODE_SMLAL) || is_smm;
		m_neg     = signed_op && item.value_m[31];

		base = '0;
		priority case (1'b1)
			op == amu_pkg::MODE_MLA:
				base = {32'd0, item.value_acc};
			(op == amu_pkg::MODE_UMLAL) || (op == amu_pkg::MODE_SMLAL):
				base = {item.value_hi, item.value_acc};
			op == amu_pkg::MODE_UMAAL:
				base = {32'd0, item.value_hi} + {32'd0, item.value_acc};
			(op == amu_pkg::MODE_SMMLA) && (item.index_aux != amu_pkg::PC_INDEX):
				base = {item.value_acc, 32'd0};
			op == amu_pkg::MODE_SMMLS:
				base = {item.value_acc, 32'd0};
			default:
				base = '0;
		endcase

		// signed multiplier: the cells see m as unsigned, so take off n<<32 when m is negative
		corr = '0;
		if (m_neg) begin
			corr = (op == amu_pkg::MODE_SMMLS) ? {item.value_n, 32'd0}
				: (64'd0 - {item.value_n, 32'd0});
		end
		rnd_add = (is_smm && item.round_enable) ? 64'h0000_0000_8000_0000 : 64'd0;

		stage.valid   = 1'b1;
		stage.sub     = (op == amu_pkg::MODE_SMMLS);
		stage.n       = signed_op ? {{32{item.value_n[31]}}, item.value_n}
			: {32'd0, item.value_n};
		stage.m       = item.value_m;
		stage.acc     = base + corr + rnd_add;
		stage.ctl.unp = unp;
		stage.ctl.wlo = go;
		stage.ctl.whi = go && is_long;
		stage.ctl.fw  = go && item.set_flags && (op <= amu_pkg::MODE_SMLAL);
		stage.ctl.msw = is_smm;
		stage.ctl.form = is_long ? amu_pkg::FORM_LONG : amu_pkg::FORM_WORD;
	end
endmodule
`default_nettype wire

/* design/amu_cell.sv */
`default_nettype none
module amu_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire amu_pkg::stage_t d,
	output amu_pkg::stage_t      q
);
	logic [63:0]     pp;
	amu_pkg::stage_t nxt;
	logic            valid_s1;
	amu_pkg::stage_t data_s1;

	// one digit of m per cell, n moves up by a digit for the next cell
	always_comb begin
		pp       = d.n * {{(64 - amu_pkg::DIGIT_W){1'b0}}, d.m[amu_pkg::DIGIT_W-1:0]};
		nxt      = d;
		nxt.acc  = d.sub ? (d.acc - pp) : (d.acc + pp);
		nxt.n    = d.n << amu_pkg::DIGIT_W;
		nxt.m    = d.m >> amu_pkg::DIGIT_W;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	always_comb begin
		q       = data_s1;
		q.valid = valid_s1;
	end
endmodule
`default_nettype wire

/* design/arm32_multiply_unit.sv */
// channel   dir  payload      carries
// in_req    in   in_item_t    one multiply instruction with operands and indices
// out_rsp   out  out_item_t   write enables, result words and N/Z update
//
// one request per cycle while out_rsp does not stall, results in request order
// pipeline: four multiplier cells of one byte each, then the output register
// the whole pipeline holds while a result waits on out_rsp.ready
// arst_n clears all valid bits; payload registers are not reset
`default_nettype none
`include "arm32_multiply_unit_defines.svh"
module arm32_multiply_unit (
	input  wire          clk,
	input  wire          arst_n,
	amu_stream_if.sink   in_req,
	amu_stream_if.source out_rsp
);
	// advance when the output register is free or being drained
	logic                  adv;
	amu_pkg::stage_t       chain [amu_pkg::NUM_CELLS + 1];
	amu_pkg::stage_t       last;
	amu_pkg::out_item_t    res;
	amu_pkg::out_item_t    res_q;
	logic                  out_valid_q;
	logic [63:0]           r;

	assign adv          = !out_valid_q || out_rsp.ready;
	assign in_req.ready = adv;

	// decode checks the encoding and seeds the accumulator
	amu_decode u_decode (
		.item  (in_req.payload),
		.stage (chain[0])
	);

	// row of multiply-accumulate cells, one byte of m each
	for (genvar g = 0; g < amu_pkg::NUM_CELLS; g++) begin : g_cell
		amu_pkg::stage_t cell_in;
		always_comb begin
			cell_in = chain[g];
			if (g == 0) begin
				cell_in.valid = in_req.valid;
			end
		end
		amu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (cell_in),
			.q      (chain[g+1])
		);
	end

	assign last = chain[amu_pkg::NUM_CELLS];
	assign r    = last.acc;

	// pick the result words and flags
	always_comb begin
		res               = '0;
		res.unpredictable = last.ctl.unp;
		res.write_low     = last.ctl.wlo;
		res.write_high    = last.ctl.whi;
		res.flags_write   = last.ctl.fw;
		unique case (last.ctl.form)
			amu_pkg::FORM_LONG: begin
				res.result_low    = last.ctl.wlo ? r[31:0] : 32'd0;
				res.result_high   = last.ctl.whi ? r[63:32] : 32'd0;
				res.flag_negative = last.ctl.fw && r[63];
				res.flag_zero     = last.ctl.fw && (r == 64'd0);
			end
			default: begin
				// word forms; most-significant-word forms take the top half
				if (last.ctl.wlo) begin
					res.result_low = last.ctl.msw ? r[63:32] : r[31:0];
				end
				res.flag_negative = last.ctl.fw && r[31];
				res.flag_zero     = last.ctl.fw && (r[31:0] == 32'd0);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_rsp.valid   = out_valid_q;
	assign out_rsp.payload = res_q;

	// an unpredictable encoding writes nothing
	`AMU_ASSERT_NOW(a_unp_no_write, clk, arst_n, out_valid_q && res_q.unpredictable, !res_q.write_low && !res_q.write_high && !res_q.flags_write)
	// flags stay clear unless they are written
	`AMU_ASSERT_NOW(a_flags_gated, clk, arst_n, out_valid_q && !res_q.flags_write, !res_q.flag_negative && !res_q.flag_zero)
	// the high word is only written with the low word
	`AMU_ASSERT_NOW(a_high_with_low, clk, arst_n, out_valid_q && res_q.write_high, res_q.write_low)
	// an accepted request enters the first cell
	`AMU_ASSERT_NEXT(a_enter_chain, clk, arst_n, in_req.valid && in_req.ready, chain[1].valid)
endmodule
`default_nettype wire
